// ----- design/gfc_pkg.sv -----
package gfc_pkg;

  // default build values
  localparam int MAX_FRAME_BYTES_DEF     = 16383;
  localparam int TUNNEL_HEADER_BYTES_DEF = 8;

  // protocol constants
  localparam logic [15:0] ETYPE_CVLAN     = 16'h8100;
  localparam logic [15:0] ETYPE_SVLAN     = 16'h88A8;
  localparam logic [15:0] ETYPE_IPV4      = 16'h0800;
  localparam logic [7:0]  PROTO_UDP       = 8'd17;
  localparam logic [15:0] TUNNEL_PORT_DEF = 16'd2152;
  localparam logic [3:0]  IP_VERSION_4    = 4'd4;

  typedef enum logic [1:0] {
    V_ABORT = 2'd0,
    V_DROP  = 2'd1,
    V_PASS  = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    ST_ETH   = 3'd0,
    ST_IP    = 3'd1,
    ST_UDP   = 3'd2,
    ST_GTP   = 3'd3,
    ST_INNER = 3'd4
  } stage_t;

  // one staged frame byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } gfc_beat_t;

endpackage

// ----- design/gfc_if.sv -----
interface gfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface gfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

// ----- design/gfc_in_stage.sv -----
module gfc_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  gfc_in_if.sink             in_chan,
  input  logic               take,
  output logic               beat_valid,
  output gfc_pkg::gfc_beat_t beat
);
  import gfc_pkg::*;

  logic      valid_r;
  gfc_beat_t beat_r;

  // room when empty or when the held byte moves on this cycle
  assign in_chan.ready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      beat_r.data <= in_chan.frame_byte;
      beat_r.last <= in_chan.frame_end;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

// ----- design/gfc_parser.sv -----
module gfc_parser #(
  parameter int MAX_FRAME_BYTES     = gfc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int TUNNEL_HEADER_BYTES = gfc_pkg::TUNNEL_HEADER_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  gfc_pkg::gfc_beat_t beat,
  input  logic [15:0]        tunnel_port,
  output gfc_pkg::verdict_t  verdict
);
  import gfc_pkg::*;

  localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = (POS_W > 7) ? POS_W : 7;

  // header offsets, untagged and tagged
  localparam int L3U  = 14;
  localparam int L3T  = 18;
  localparam int U4U  = L3U + 20;
  localparam int U4T  = L3T + 20;
  localparam int GTU  = U4U + 8;
  localparam int GTT  = U4T + 8;
  localparam int IN4U = GTU + TUNNEL_HEADER_BYTES;
  localparam int IN4T = GTT + TUNNEL_HEADER_BYTES;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_FRAME_BYTES);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             tagged_r, tagged_upd;
  logic [7:0]       held_r, held_upd;
  verdict_t         early_r, early_upd;
  logic             fixed_r, fixed_upd;
  stage_t           stage_r, stage_upd;

  logic [CMP_W-1:0] pos;
  logic [15:0]      ethertype;
  logic [CMP_W-1:0] off_proto, off_ip_end, off_port_hi, off_port_lo, off_udp_end;
  logic [CMP_W-1:0] off_gtp_end, off_inner, off_inner_end;

  assign pos       = CMP_W'(pos_r);
  assign ethertype = {held_r, beat.data};

  assign off_proto     = tagged_r ? CMP_W'(L3T + 9)  : CMP_W'(L3U + 9);
  assign off_ip_end    = tagged_r ? CMP_W'(L3T + 19) : CMP_W'(L3U + 19);
  assign off_port_hi   = tagged_r ? CMP_W'(U4T + 2)  : CMP_W'(U4U + 2);
  assign off_port_lo   = tagged_r ? CMP_W'(U4T + 3)  : CMP_W'(U4U + 3);
  assign off_udp_end   = tagged_r ? CMP_W'(U4T + 7)  : CMP_W'(U4U + 7);
  assign off_gtp_end   = tagged_r ? CMP_W'(GTT + TUNNEL_HEADER_BYTES - 1)
                                  : CMP_W'(GTU + TUNNEL_HEADER_BYTES - 1);
  assign off_inner     = tagged_r ? CMP_W'(IN4T) : CMP_W'(IN4U);
  assign off_inner_end = tagged_r ? CMP_W'(IN4T + 19) : CMP_W'(IN4U + 19);

  // next stage
  always_comb begin
    stage_upd = stage_r;
    if (!fixed_r) begin
      unique case (stage_r)
        ST_ETH: begin
          if (pos == CMP_W'(13) && (ethertype == ETYPE_CVLAN ||
              ethertype == ETYPE_SVLAN || ethertype == ETYPE_IPV4)) begin
            stage_upd = ST_IP;
          end
        end
        ST_IP: begin
          if (pos == off_ip_end && held_upd == PROTO_UDP) begin
            stage_upd = ST_UDP;
          end
        end
        ST_UDP: begin
          if (pos == off_udp_end && held_r != 8'd0) begin
            stage_upd = ST_GTP;
          end
        end
        ST_GTP: begin
          if (pos == off_gtp_end) begin
            stage_upd = ST_INNER;
          end
        end
        ST_INNER: begin
          stage_upd = ST_INNER;
        end
        default: begin
          stage_upd = stage_r;
        end
      endcase
    end
  end

  // field capture and early decisions
  always_comb begin
    tagged_upd = tagged_r;
    held_upd   = held_r;
    early_upd  = early_r;
    fixed_upd  = fixed_r;
    if (!fixed_r) begin
      unique case (stage_r)
        ST_ETH: begin
          if (pos == CMP_W'(12)) begin
            held_upd = beat.data;
          end else if (pos == CMP_W'(13)) begin
            if (ethertype == ETYPE_CVLAN || ethertype == ETYPE_SVLAN) begin
              tagged_upd = 1'b1;
            end else if (ethertype != ETYPE_IPV4) begin
              early_upd = V_PASS;
              fixed_upd = 1'b1;
            end
          end
        end
        ST_IP: begin
          if (pos == off_proto) begin
            held_upd = beat.data;
          end
          if (pos == off_ip_end && held_upd != PROTO_UDP) begin
            early_upd = V_PASS;
            fixed_upd = 1'b1;
          end
        end
        ST_UDP: begin
          if (pos == off_port_hi) begin
            held_upd = beat.data;
          end else if (pos == off_port_lo) begin
            held_upd = ({held_r, beat.data} == tunnel_port) ? 8'd1 : 8'd0;
          end else if (pos == off_udp_end && held_r == 8'd0) begin
            early_upd = V_PASS;
            fixed_upd = 1'b1;
          end
        end
        ST_GTP: begin
          held_upd = held_r;
        end
        ST_INNER: begin
          if (pos == off_inner) begin
            held_upd = {4'd0, beat.data[7:4]};
          end
          if (pos == off_inner_end) begin
            early_upd = (held_upd == {4'd0, IP_VERSION_4}) ? V_PASS : V_DROP;
            fixed_upd = 1'b1;
          end
        end
        default: begin
          held_upd = held_r;
        end
      endcase
    end
  end

  // verdict on the updated state, used only on a last byte
  always_comb begin
    if (fixed_upd) begin
      verdict = early_upd;
    end else begin
      case (stage_upd) inside
        ST_ETH:         verdict = V_PASS;
        ST_IP, ST_UDP:  verdict = V_ABORT;
        default:        verdict = V_DROP;
      endcase
    end
  end

  always_comb begin
    if (beat.last) begin
      pos_nxt = '0;
    end else if (pos_r < POS_MAX) begin
      pos_nxt = pos_r + POS_W'(1);
    end else begin
      pos_nxt = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      tagged_r <= 1'b0;
      held_r   <= '0;
      early_r  <= V_PASS;
      fixed_r  <= 1'b0;
      stage_r  <= ST_ETH;
    end else if (step) begin
      pos_r <= pos_nxt;
      if (beat.last) begin
        tagged_r <= 1'b0;
        held_r   <= '0;
        early_r  <= V_PASS;
        fixed_r  <= 1'b0;
        stage_r  <= ST_ETH;
      end else begin
        tagged_r <= tagged_upd;
        held_r   <= held_upd;
        early_r  <= early_upd;
        fixed_r  <= fixed_upd;
        stage_r  <= stage_upd;
      end
    end
  end

endmodule

// ----- design/gtpu_frame_classifier_top.sv -----
// channel   direction  fields                         transaction
// in_chan   sink       frame_byte[7:0], frame_end     one frame byte
// out_chan  source     verdict[1:0] (abort/drop/pass) one verdict per frame end
// cfg_      write      cfg_we, cfg_wdata[15:0]        tunnel udp port
//
// one byte per cycle, but a last byte waits while a verdict is unsent; bytes are
// held in the input register, a last byte's verdict goes to the output register
// rate is set by the combinational parser update between the two registers
// rst_n is synchronous, active low: parser returns to the ethernet stage and
// the tunnel port to 2152; a stalled verdict holds only last bytes back
module gtpu_frame_classifier_top #(
  parameter int MAX_FRAME_BYTES     = gfc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int TUNNEL_HEADER_BYTES = gfc_pkg::TUNNEL_HEADER_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  gfc_in_if.sink      in_chan,
  gfc_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);
  import gfc_pkg::*;

  logic        beat_valid;
  gfc_beat_t   beat;
  logic        take;
  verdict_t    verdict;
  logic [15:0] tunnel_port_r;
  logic        out_valid_r;
  verdict_t    out_verdict_r;

  // tunnel port register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tunnel_port_r <= TUNNEL_PORT_DEF;
    end else if (cfg_we) begin
      tunnel_port_r <= cfg_wdata;
    end
  end

  // a middle byte always moves on; a last byte needs a free output slot
  assign take = beat_valid && (!beat.last || !out_valid_r || out_chan.ready);

  gfc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  gfc_parser #(
    .MAX_FRAME_BYTES     (MAX_FRAME_BYTES),
    .TUNNEL_HEADER_BYTES (TUNNEL_HEADER_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (take),
    .beat        (beat),
    .tunnel_port (tunnel_port_r),
    .verdict     (verdict)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && beat.last) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && beat.last) begin
      out_verdict_r <= verdict;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.verdict = out_verdict_r;

endmodule
